[design/i2cee_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cee_pkg
// Shared constants and types for the I2C EEPROM random read master.
// ---------------------------------------------------------------------------
package i2cee_pkg;

  localparam int unsigned DEF_MAX_READ_LENGTH = 256;

  // Device type code of a serial EEPROM, upper nibble of the device byte
  localparam logic [3:0] DEVICE_PREAMBLE = 4'b1010;
  // Clock pulses sent to free a stuck slave
  localparam logic [3:0] LINE_RESET_PULSES = 4'd9;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } res_t;

endpackage
`default_nettype wire

[design/i2cee_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cee channel interfaces
// Valid/ready channels for tick items in and line/result items out.
// ---------------------------------------------------------------------------
interface i2cee_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] device_select;
  logic [7:0] start_address;
  logic [8:0] read_length;
  logic       sda_in;

  modport source (
    output valid, command, device_select, start_address, read_length, sda_in,
    input  ready
  );
  modport sink (
    input  valid, command, device_select, start_address, read_length, sda_in,
    output ready
  );
endinterface

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_enable;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       busy_res;
  logic       done_res;
  logic       success;

  modport source (
    output valid, scl_level, sda_level, sda_enable, byte_valid, data_byte,
           last_byte, busy_res, done_res, success,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_enable, byte_valid, data_byte,
           last_byte, busy_res, done_res, success,
    output ready
  );
endinterface
`default_nettype wire

[design/i2c_eeprom_random_read_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_eeprom_random_read_core
// I2C master for random-address EEPROM reads, one quarter bit period per item.
// ---------------------------------------------------------------------------
//  Channel  Dir  Carries
//  cmd      in   tick: command, device_select, start_address, read_length, sda_in
//  rsp      out  SCL/SDA levels, received byte, busy/done/success
//
//  One tick item in, one result item out; a new item is taken every cycle while the
//  result register is free or being taken. The sequencer state and the result
//  register load on the accepting edge; the result is valid the next cycle.
//  cmd.ready follows that register, so a stalled sink holds result and sequencer.
//  Synchronous reset returns the sequencer to idle and empties the result register.
// ---------------------------------------------------------------------------
module i2c_eeprom_random_read_core #(
  parameter int unsigned MAX_READ_LENGTH = i2cee_pkg::DEF_MAX_READ_LENGTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  i2cee_in_if.sink    cmd,
  i2cee_out_if.source rsp
);
  import i2cee_pkg::*;

  logic accept;
  logic can_load;
  res_t seq_res;
  res_t out_res;

  assign cmd.ready = can_load;
  assign accept    = cmd.valid && can_load;

  i2cee_seq #(
    .MAX_READ_LENGTH(MAX_READ_LENGTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .command      (cmd.command),
    .device_select(cmd.device_select),
    .start_address(cmd.start_address),
    .read_length  (cmd.read_length),
    .sda_in       (cmd.sda_in),
    .res          (seq_res)
  );

  i2cee_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (cmd.valid),
    .res_in  (seq_res),
    .can_load(can_load),
    .valid   (rsp.valid),
    .ready   (rsp.ready),
    .res_out (out_res)
  );

  assign rsp.scl_level  = out_res.scl_level;
  assign rsp.sda_level  = out_res.sda_level;
  assign rsp.sda_enable = out_res.sda_enable;
  assign rsp.byte_valid = out_res.byte_valid;
  assign rsp.data_byte  = out_res.data_byte;
  assign rsp.last_byte  = out_res.last_byte;
  assign rsp.busy_res   = out_res.busy_res;
  assign rsp.done_res   = out_res.done_res;
  assign rsp.success    = out_res.success;

endmodule
`default_nettype wire

[design/i2cee_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cee_seq
// Quarter-period bus sequencer: state registers plus next-state/result logic.
// ---------------------------------------------------------------------------
module i2cee_seq #(
  parameter int unsigned MAX_READ_LENGTH = i2cee_pkg::DEF_MAX_READ_LENGTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              command,
  input  wire logic [2:0]        device_select,
  input  wire logic [7:0]        start_address,
  input  wire logic [8:0]        read_length,
  input  wire logic              sda_in,
  output i2cee_pkg::res_t        res
);
  import i2cee_pkg::*;

  localparam int unsigned BL_W  = $clog2(MAX_READ_LENGTH + 1);
  localparam int unsigned CMP_W = (BL_W > 9) ? BL_W : 9;

  localparam logic [3:0] P_IDLE      = 4'd0;
  localparam logic [3:0] P_RST_HOLD  = 4'd1;
  localparam logic [3:0] P_RST_PULSE = 4'd2;
  localparam logic [3:0] P_RST_REL   = 4'd3;
  localparam logic [3:0] P_RST_STOP  = 4'd4;
  localparam logic [3:0] P_RST_TAIL  = 4'd5;
  localparam logic [3:0] P_START     = 4'd6;
  localparam logic [3:0] P_TX        = 4'd7;
  localparam logic [3:0] P_TX_ACK    = 4'd8;
  localparam logic [3:0] P_GAP       = 4'd9;
  localparam logic [3:0] P_RX_LEAD   = 4'd10;
  localparam logic [3:0] P_RX        = 4'd11;
  localparam logic [3:0] P_RX_ACK    = 4'd12;
  localparam logic [3:0] P_FSTOP     = 4'd13;

  logic [3:0]      phase, phase_next;
  logic            fail, fail_next;
  logic [2:0]      quarter_count, quarter_count_next;
  logic [2:0]      bit_count, bit_count_next;
  logic [3:0]      pulse_count, pulse_count_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [BL_W-1:0] bytes_left, bytes_left_next;
  logic [2:0]      saved_select, saved_select_next;
  logic [7:0]      saved_address, saved_address_next;

  logic            load;
  logic [3:0]      c_phase;
  logic [2:0]      c_q;
  logic [CMP_W-1:0] len_ext;
  logic [BL_W-1:0] len_sat;
  logic [7:0]      rx_byte;

  // Byte sent in transmit slot idx: 0 = device write, 1 = memory address, 2 = device read
  function automatic logic [7:0] tx_byte(input logic [3:0] idx, input logic [2:0] sel,
                                         input logic [7:0] addr);
    logic [7:0] b;
    if (idx == 4'd0) b = {DEVICE_PREAMBLE, sel, 1'b0};
    else if (idx == 4'd1) b = addr;
    else b = {DEVICE_PREAMBLE, sel, 1'b1};
    return b;
  endfunction

  assign len_ext = CMP_W'(read_length);
  assign len_sat = (len_ext > CMP_W'(MAX_READ_LENGTH)) ? BL_W'(MAX_READ_LENGTH)
                                                       : BL_W'(len_ext);

  assign load = (phase == P_IDLE) && command;

  always_comb begin
    c_phase            = load ? P_RST_HOLD : phase;
    c_q                = load ? 3'd0 : quarter_count;
    fail_next          = load ? 1'b0 : fail;
    bit_count_next     = load ? 3'd0 : bit_count;
    pulse_count_next   = load ? 4'd0 : pulse_count;
    shift_byte_next    = load ? 8'd0 : shift_byte;
    bytes_left_next    = load ? len_sat : bytes_left;
    saved_select_next  = load ? device_select : saved_select;
    saved_address_next = load ? start_address : saved_address;
    phase_next         = c_phase;
    quarter_count_next = c_q;
    rx_byte            = {shift_byte_next[6:0], sda_in};

    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.sda_enable = 1'b0;

    if (c_phase != P_IDLE) begin
      res.busy_res = 1'b1;
      unique case (c_phase)
        P_RST_HOLD: begin
          res.sda_enable = 1'b1;
          if (c_q == 3'd7) begin
            phase_next = P_RST_PULSE;
            quarter_count_next = 3'd0;
            pulse_count_next = 4'd0;
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_RST_PULSE: begin
          res.sda_enable = 1'b1;
          res.scl_level = (c_q >= 3'd2);
          if (c_q >= 3'd3) begin
            quarter_count_next = 3'd0;
            if (pulse_count_next + 4'd1 >= LINE_RESET_PULSES) phase_next = P_RST_REL;
            else pulse_count_next = pulse_count_next + 4'd1;
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_RST_REL: begin
          res.scl_level = 1'b0;
          phase_next = P_RST_STOP;
          quarter_count_next = 3'd0;
        end
        P_RST_STOP, P_FSTOP: begin
          res.sda_enable = 1'b1;
          res.scl_level = (c_q >= 3'd1);
          res.sda_level = (c_q >= 3'd2);
          if (c_q >= 3'd2) begin
            quarter_count_next = 3'd0;
            if (c_phase == P_FSTOP) begin
              res.done_res = 1'b1;
              res.success = 1'b1;
              phase_next = P_IDLE;
            end else begin
              phase_next = P_RST_TAIL;
            end
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_RST_TAIL: begin
          if (c_q == 3'd7) begin
            quarter_count_next = 3'd0;
            if (fail_next) begin
              res.done_res = 1'b1;
              phase_next = P_IDLE;
            end else begin
              phase_next = P_START;
              pulse_count_next = 4'd0;
            end
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_START: begin
          res.sda_enable = 1'b1;
          res.scl_level = (c_q < 3'd2);
          res.sda_level = (c_q == 3'd0);
          if (c_q >= 3'd2) begin
            shift_byte_next = tx_byte(pulse_count_next, saved_select_next,
                                      saved_address_next);
            phase_next = P_TX;
            quarter_count_next = 3'd0;
            bit_count_next = 3'd0;
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_TX: begin
          res.sda_enable = 1'b1;
          res.scl_level = (c_q == 3'd1) || (c_q == 3'd2);
          res.sda_level = shift_byte_next[7];
          if (c_q >= 3'd3) begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            quarter_count_next = 3'd0;
            if (bit_count_next == 3'd7) begin
              phase_next = P_TX_ACK;
              bit_count_next = 3'd0;
            end else begin
              bit_count_next = bit_count_next + 3'd1;
            end
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_TX_ACK: begin
          res.sda_level = 1'b0;
          res.scl_level = (c_q == 3'd1) || (c_q == 3'd2);
          if (c_q == 3'd2) shift_byte_next = {7'd0, sda_in};
          if (c_q >= 3'd3) begin
            quarter_count_next = 3'd0;
            if (shift_byte_next[0]) begin
              // no ack: free the bus, then report failure
              phase_next = P_RST_HOLD;
              fail_next = 1'b1;
              pulse_count_next = 4'd0;
            end else if (pulse_count_next == 4'd0) begin
              pulse_count_next = 4'd1;
              shift_byte_next = tx_byte(4'd1, saved_select_next, saved_address_next);
              phase_next = P_TX;
              bit_count_next = 3'd0;
            end else if (pulse_count_next == 4'd1) begin
              phase_next = P_GAP;
            end else begin
              phase_next = (bytes_left_next == '0) ? P_FSTOP : P_RX_LEAD;
            end
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_GAP: begin
          res.scl_level = 1'b0;
          res.sda_level = 1'b0;
          phase_next = P_START;
          pulse_count_next = 4'd2;
          quarter_count_next = 3'd0;
        end
        P_RX_LEAD: begin
          res.scl_level = 1'b0;
          res.sda_level = 1'b0;
          shift_byte_next = 8'd0;
          bit_count_next = 3'd0;
          quarter_count_next = 3'd0;
          phase_next = P_RX;
        end
        P_RX: begin
          res.sda_level = 1'b0;
          res.scl_level = (c_q == 3'd1) || (c_q == 3'd2);
          if (c_q == 3'd2) begin
            shift_byte_next = rx_byte;
            if (bit_count_next == 3'd7) begin
              res.byte_valid = 1'b1;
              res.data_byte = rx_byte;
              res.last_byte = (bytes_left_next == BL_W'(1));
            end
          end
          if (c_q >= 3'd3) begin
            quarter_count_next = 3'd0;
            if (bit_count_next == 3'd7) begin
              phase_next = P_RX_ACK;
              bit_count_next = 3'd0;
            end else begin
              bit_count_next = bit_count_next + 3'd1;
            end
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        P_RX_ACK: begin
          res.sda_enable = 1'b1;
          res.sda_level = (bytes_left_next <= BL_W'(1));
          res.scl_level = (c_q == 3'd1) || (c_q == 3'd2);
          if (c_q >= 3'd3) begin
            quarter_count_next = 3'd0;
            phase_next = (bytes_left_next <= BL_W'(1)) ? P_FSTOP : P_RX_LEAD;
            if (bytes_left_next != '0) bytes_left_next = bytes_left_next - BL_W'(1);
          end else begin
            quarter_count_next = c_q + 3'd1;
          end
        end
        default: begin
          phase_next = P_IDLE;
          fail_next = 1'b0;
          quarter_count_next = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= P_IDLE;
      fail          <= 1'b0;
      quarter_count <= 3'd0;
      bit_count     <= 3'd0;
      pulse_count   <= 4'd0;
      shift_byte    <= 8'd0;
      bytes_left    <= '0;
      saved_select  <= 3'd0;
      saved_address <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      fail          <= (phase_next == P_IDLE) ? 1'b0 : fail_next;
      quarter_count <= quarter_count_next;
      bit_count     <= bit_count_next;
      pulse_count   <= pulse_count_next;
      shift_byte    <= shift_byte_next;
      bytes_left    <= bytes_left_next;
      saved_select  <= saved_select_next;
      saved_address <= saved_address_next;
    end
  end

endmodule
`default_nettype wire

[design/i2cee_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cee_out_reg
// Result register: holds one item until the sink takes it.
// ---------------------------------------------------------------------------
module i2cee_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire i2cee_pkg::res_t res_in,
  output logic                 can_load,
  output logic                 valid,
  input  wire logic            ready,
  output i2cee_pkg::res_t      res_out
);
  import i2cee_pkg::*;

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

[verif/i2c_eeprom_random_read_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_eeprom_random_read_core_tb
// Drives quarter-period ticks into the I2C EEPROM read master, plays the
// EEPROM side on sda_in (acks, nacks, data bits) and checks every line/result
// item against a cycle-true predictor of the sequencer. Both channels idle
// at random; a few directed reads come first, then random reads.
// ---------------------------------------------------------------------------
module i2c_eeprom_random_read_core_tb;
  import i2cee_pkg::*;

  localparam int unsigned MAX_LEN = DEF_MAX_READ_LENGTH;
  localparam int unsigned NO_NACK = 3;
  localparam int unsigned DATA_RANDOM = 0;
  localparam int unsigned DATA_ZEROS = 1;
  localparam int unsigned DATA_ONES = 2;
  localparam int unsigned RANDOM_TICKS = 400;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RST_HOLD, ST_RST_PULSE, ST_RST_REL, ST_RST_STOP, ST_RST_TAIL,
    ST_START, ST_TX, ST_TX_ACK, ST_GAP, ST_RX_LEAD, ST_RX, ST_RX_ACK, ST_FSTOP
  } seq_state_e;

  typedef struct packed {
    logic       command;
    logic [2:0] device_select;
    logic [7:0] start_address;
    logic [8:0] read_length;
    logic       sda_in;
  } tick_t;

  function automatic string line_str(res_t r);
    return $sformatf("scl=%b sda=%b en=%b bv=%b byte=%h last=%b busy=%b done=%b ok=%b",
                     r.scl_level, r.sda_level, r.sda_enable, r.byte_valid,
                     r.data_byte, r.last_byte, r.busy_res, r.done_res, r.success);
  endfunction

  class line_scoreboard;
    seq_state_e state = ST_IDLE;
    bit         aborting = 1'b0;
    bit [3:0]   quarter = '0;
    bit [3:0]   bit_idx = '0;
    bit [3:0]   pulse = '0;
    bit [7:0]   shreg = '0;
    bit [8:0]   remaining = '0;
    bit [2:0]   dev_sel = '0;
    bit [7:0]   mem_addr = '0;
    res_t       expected_lines[$];
    int         mismatches = 0;

    function void load_tx(bit [3:0] idx);
      bit [7:0] dev_byte;
      dev_byte = {DEVICE_PREAMBLE, dev_sel, 1'b0};
      pulse = idx;
      if (idx == 0) shreg = dev_byte;
      else if (idx == 1) shreg = mem_addr;
      else shreg = dev_byte | 8'h01;
      state = ST_TX;
      quarter = '0;
      bit_idx = '0;
    endfunction

    function void note_tick(tick_t t);
      res_t     e;
      bit [3:0] q;
      e = '0;
      e.scl_level = 1'b1;
      e.sda_level = 1'b1;
      if (state == ST_IDLE && t.command) begin
        remaining = (t.read_length > MAX_LEN) ? 9'(MAX_LEN) : t.read_length;
        dev_sel = t.device_select;
        mem_addr = t.start_address;
        state = ST_RST_HOLD;
        aborting = 1'b0;
        quarter = '0;
        bit_idx = '0;
        pulse = '0;
        shreg = '0;
      end
      if (state != ST_IDLE) begin
        e.busy_res = 1'b1;
        q = quarter;
        case (state)
          ST_RST_HOLD: begin
            e.sda_enable = 1'b1;
            if (q >= 7) begin
              state = ST_RST_PULSE;
              quarter = '0;
              pulse = '0;
            end else quarter = q + 4'd1;
          end
          ST_RST_PULSE: begin
            e.sda_enable = 1'b1;
            e.scl_level = (q >= 2);
            if (q >= 3) begin
              quarter = '0;
              if (int'(pulse) + 1 >= int'(LINE_RESET_PULSES)) state = ST_RST_REL;
              else pulse = pulse + 4'd1;
            end else quarter = q + 4'd1;
          end
          ST_RST_REL: begin
            e.scl_level = 1'b0;
            state = ST_RST_STOP;
            quarter = '0;
          end
          ST_RST_STOP: begin
            e.sda_enable = 1'b1;
            e.scl_level = (q >= 1);
            e.sda_level = (q >= 2);
            if (q >= 2) begin
              state = ST_RST_TAIL;
              quarter = '0;
            end else quarter = q + 4'd1;
          end
          ST_RST_TAIL: begin
            if (q >= 7) begin
              quarter = '0;
              if (aborting) begin
                e.done_res = 1'b1;
                state = ST_IDLE;
                aborting = 1'b0;
              end else begin
                state = ST_START;
                pulse = '0;
              end
            end else quarter = q + 4'd1;
          end
          ST_START: begin
            e.sda_enable = 1'b1;
            e.scl_level = (q < 2);
            e.sda_level = (q == 0);
            if (q >= 2) load_tx(pulse);
            else quarter = q + 4'd1;
          end
          ST_TX: begin
            e.sda_enable = 1'b1;
            e.scl_level = (q == 1 || q == 2);
            e.sda_level = shreg[7];
            if (q >= 3) begin
              shreg = shreg << 1;
              quarter = '0;
              if (bit_idx >= 7) begin
                state = ST_TX_ACK;
                bit_idx = '0;
              end else bit_idx = bit_idx + 4'd1;
            end else quarter = q + 4'd1;
          end
          ST_TX_ACK: begin
            e.sda_level = 1'b0;
            e.scl_level = (q == 1 || q == 2);
            if (q == 2) shreg = {7'b0, t.sda_in};
            if (q >= 3) begin
              quarter = '0;
              if (shreg[0]) begin
                // nack: free the bus, then report failure
                state = ST_RST_HOLD;
                aborting = 1'b1;
                pulse = '0;
              end else if (pulse == 0) load_tx(4'd1);
              else if (pulse == 1) state = ST_GAP;
              else state = (remaining == 0) ? ST_FSTOP : ST_RX_LEAD;
            end else quarter = q + 4'd1;
          end
          ST_GAP: begin
            e.scl_level = 1'b0;
            e.sda_level = 1'b0;
            state = ST_START;
            pulse = 4'd2;
            quarter = '0;
          end
          ST_RX_LEAD: begin
            e.scl_level = 1'b0;
            e.sda_level = 1'b0;
            shreg = '0;
            bit_idx = '0;
            quarter = '0;
            state = ST_RX;
          end
          ST_RX: begin
            e.sda_level = 1'b0;
            e.scl_level = (q == 1 || q == 2);
            if (q == 2) begin
              shreg = {shreg[6:0], t.sda_in};
              if (bit_idx >= 7) begin
                e.byte_valid = 1'b1;
                e.data_byte = shreg;
                e.last_byte = (remaining == 1);
              end
            end
            if (q >= 3) begin
              quarter = '0;
              if (bit_idx >= 7) begin
                state = ST_RX_ACK;
                bit_idx = '0;
              end else bit_idx = bit_idx + 4'd1;
            end else quarter = q + 4'd1;
          end
          ST_RX_ACK: begin
            e.sda_enable = 1'b1;
            e.sda_level = (remaining <= 1);
            e.scl_level = (q == 1 || q == 2);
            if (q >= 3) begin
              quarter = '0;
              if (remaining > 0) remaining = remaining - 9'd1;
              state = (remaining == 0) ? ST_FSTOP : ST_RX_LEAD;
            end else quarter = q + 4'd1;
          end
          ST_FSTOP: begin
            e.sda_enable = 1'b1;
            e.scl_level = (q >= 1);
            e.sda_level = (q >= 2);
            if (q >= 2) begin
              e.done_res = 1'b1;
              e.success = 1'b1;
              state = ST_IDLE;
              quarter = '0;
            end else quarter = q + 4'd1;
          end
          default: begin
            state = ST_IDLE;
            quarter = '0;
          end
        endcase
      end
      expected_lines.push_back(e);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
    endfunction

    function void check_result(res_t got);
      res_t  e;
      string diff;
      if (expected_lines.size() == 0) begin
        report({"result with nothing pending: ", line_str(got)});
        return;
      end
      e = expected_lines.pop_front();
      diff = "";
      if (got.scl_level !== e.scl_level) diff = {diff, " scl_level"};
      if (got.sda_level !== e.sda_level) diff = {diff, " sda_level"};
      if (got.sda_enable !== e.sda_enable) diff = {diff, " sda_enable"};
      if (got.byte_valid !== e.byte_valid) diff = {diff, " byte_valid"};
      if (got.data_byte !== e.data_byte) diff = {diff, " data_byte"};
      if (got.last_byte !== e.last_byte) diff = {diff, " last_byte"};
      if (got.busy_res !== e.busy_res) diff = {diff, " busy_res"};
      if (got.done_res !== e.done_res) diff = {diff, " done_res"};
      if (got.success !== e.success) diff = {diff, " success"};
      if (diff != "")
        report({"field(s)", diff, "; expected ", line_str(e), " got ", line_str(got)});
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  i2cee_in_if  cmd_if ();
  i2cee_out_if rsp_if ();

  i2c_eeprom_random_read_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  line_scoreboard sb = new();

  // EEPROM behavior for the read in progress
  int unsigned nack_at = NO_NACK;
  int unsigned rx_mode = DATA_RANDOM;
  bit          quiet_links = 1'b0;
  int unsigned tick_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return quiet_links ? 0 : $urandom_range(0, 18);
  endfunction

  // SDA as the EEPROM would hold it for the next quarter
  function automatic bit pick_sda();
    if (sb.state == ST_TX_ACK && sb.quarter == 2) return (sb.pulse == nack_at);
    if (sb.state == ST_RX && sb.quarter == 2) begin
      if (rx_mode == DATA_ZEROS) return 1'b0;
      if (rx_mode == DATA_ONES) return 1'b1;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic drive_tick(bit c, bit [2:0] d, bit [7:0] a, bit [8:0] l);
    int unsigned gap;
    tick_t       t;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk);
    t.command = c;
    t.device_select = d;
    t.start_address = a;
    t.read_length = l;
    t.sda_in = pick_sda();
    cmd_if.valid <= 1'b1;
    cmd_if.command <= t.command;
    cmd_if.device_select <= t.device_select;
    cmd_if.start_address <= t.start_address;
    cmd_if.read_length <= t.read_length;
    cmd_if.sda_in <= t.sda_in;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_tick(t);
    tick_count++;
  endtask

  task automatic noise_tick(bit allow_cmd);
    drive_tick(allow_cmd && ($urandom_range(0, 15) == 0), 3'($urandom_range(0, 7)),
               8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
  endtask

  task automatic run_read(bit [2:0] d, bit [7:0] a, bit [8:0] l,
                          int unsigned nack_idx, int unsigned data_mode);
    nack_at = nack_idx;
    rx_mode = data_mode;
    repeat ($urandom_range(0, 3)) noise_tick(1'b0);
    drive_tick(1'b1, d, a, l);
    // commands during the read must be ignored
    while (sb.state != ST_IDLE) noise_tick(1'b1);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // result side: random stalls per item
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        rsp_if.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.scl_level = rsp_if.scl_level;
      got.sda_level = rsp_if.sda_level;
      got.sda_enable = rsp_if.sda_enable;
      got.byte_valid = rsp_if.byte_valid;
      got.data_byte = rsp_if.data_byte;
      got.last_byte = rsp_if.last_byte;
      got.busy_res = rsp_if.busy_res;
      got.done_res = rsp_if.done_res;
      got.success = rsp_if.success;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned reads;
    int unsigned len;
    int unsigned nk;
    int unsigned drain_wait;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.command = 1'b0;
    cmd_if.device_select = '0;
    cmd_if.start_address = '0;
    cmd_if.read_length = '0;
    cmd_if.sda_in = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed reads
    run_read(3'd0, 8'h00, 9'd0, NO_NACK, DATA_RANDOM);
    quiet_links = 1'b1;
    run_read(3'd7, 8'hFF, 9'd1, NO_NACK, DATA_ONES);
    quiet_links = 1'b0;
    run_read(3'd5, 8'hA5, 9'd2, NO_NACK, DATA_ZEROS);
    run_read(3'd2, 8'h5A, 9'd3, 0, DATA_RANDOM);
    run_read(3'd4, 8'h81, 9'd3, 1, DATA_RANDOM);
    // above the limit, cut short by a nack on the device read byte
    run_read(3'd3, 8'h3C, 9'h1FF, 2, DATA_RANDOM);
    hold_until_drained();

    // random reads, mostly short; long ones get cut by a nack
    tick_count = 0;
    reads = 0;
    while (tick_count < RANDOM_TICKS || reads < 2) begin
      quiet_links = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 4);
      if (len > 8) nk = $urandom_range(0, 2);
      else nk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : NO_NACK;
      run_read(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 9'(len), nk,
               $urandom_range(DATA_RANDOM, DATA_ONES));
      reads++;
      if (reads == 1) hold_until_drained();
    end

    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    drain_wait = 10;
    repeat (drain_wait) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[i2c_eeprom_random_read_core.f]
design/i2cee_pkg.sv
design/i2cee_ifs.sv
design/i2cee_seq.sv
design/i2cee_out_reg.sv
design/i2c_eeprom_random_read_core.sv
verif/i2c_eeprom_random_read_core_tb.sv
